@@ hdl/anp_pkg.sv @@
// Shared types and character codes for the ASCII number entry parser.
package anp_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 16;
    localparam int COUNT_W = 16;
    localparam int DIGIT_W = 4;

    // Control characters
    localparam logic [CHAR_W-1:0] CHAR_BS = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;

    // Digit character ranges
    localparam logic [CHAR_W-1:0] CHAR_0  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UA = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UF = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_LA = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF = 8'h66;

    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'hA;

    // Radix selection
    localparam logic RADIX_DEC = 1'b0;
    localparam logic RADIX_HEX = 1'b1;

    // Reciprocal of ten: floor(x/10) == (x * DIV10_MUL) >> DIV10_SHIFT for 16-bit x
    localparam int DIV10_SHIFT = 19;
    localparam logic [31:0] DIV10_MUL = 32'd52429;

    // Output width of tdata: echo_valid, echo_char, value, padded to bytes
    localparam int OUT_DATA_W = 32;

    typedef struct packed {
        logic               echo_valid;
        logic [CHAR_W-1:0]  echo_char;
        logic               done_res;
        logic [VALUE_W-1:0] value;
    } anp_result_t;

endpackage

@@ hdl/anp_step.sv @@
// Per-item decode and accumulator update for the number entry parser.
module anp_step (
    input  logic                         radix_mode,
    input  logic [anp_pkg::CHAR_W-1:0]   rx_char,
    input  logic [anp_pkg::VALUE_W-1:0]  accum,
    input  logic [anp_pkg::COUNT_W-1:0]  count,
    output logic [anp_pkg::VALUE_W-1:0]  accum_next,
    output logic [anp_pkg::COUNT_W-1:0]  count_next,
    output anp_pkg::anp_result_t         result
);
    import anp_pkg::*;

    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic [CHAR_W-1:0]  offs;
    logic [VALUE_W-1:0] times_radix;
    logic [VALUE_W-1:0] div_radix;
    logic [31:0]        div10_prod;

    // Classify the byte and get its digit value
    always_comb
    begin
        is_digit = 1'b0;
        digit    = '0;
        offs     = '0;
        case (rx_char) inside
            [CHAR_0:CHAR_9]:
            begin
                offs     = rx_char - CHAR_0;
                is_digit = 1'b1;
                digit    = offs[DIGIT_W-1:0];
            end
            [CHAR_UA:CHAR_UF]:
            begin
                offs     = rx_char - CHAR_UA;
                is_digit = (radix_mode == RADIX_HEX);
                digit    = offs[DIGIT_W-1:0] + DIGIT_TEN;
            end
            [CHAR_LA:CHAR_LF]:
            begin
                offs     = rx_char - CHAR_LA;
                is_digit = (radix_mode == RADIX_HEX);
                digit    = offs[DIGIT_W-1:0] + DIGIT_TEN;
            end
            default:
            begin
                is_digit = 1'b0;
            end
        endcase
    end

    // Shift-and-add multiply by the radix; shift divide by sixteen, reciprocal divide by ten
    assign div10_prod = {16'b0, accum} * DIV10_MUL;

    always_comb
    begin
        if (radix_mode == RADIX_HEX)
        begin
            times_radix = {accum[VALUE_W-5:0], 4'b0};
            div_radix   = {4'b0, accum[VALUE_W-1:4]};
        end
        else
        begin
            times_radix = {accum[VALUE_W-4:0], 3'b0} + {accum[VALUE_W-2:0], 1'b0};
            div_radix   = {3'b0, div10_prod[DIV10_SHIFT+12:DIV10_SHIFT]};
        end
    end

    // State update and result
    always_comb
    begin
        accum_next        = accum;
        count_next        = count;
        result.echo_valid = 1'b0;
        result.echo_char  = '0;
        result.done_res   = 1'b0;
        result.value      = accum;
        if (rx_char == CHAR_CR)
        begin
            accum_next      = '0;
            count_next      = '0;
            result.done_res = 1'b1;
        end
        else if (is_digit)
        begin
            accum_next        = times_radix + {{(VALUE_W-DIGIT_W){1'b0}}, digit};
            count_next        = count + 1'b1;
            result.echo_valid = 1'b1;
            result.echo_char  = rx_char;
            result.value      = accum_next;
        end
        else if (rx_char == CHAR_BS && count != '0)
        begin
            accum_next        = div_radix;
            count_next        = count - 1'b1;
            result.echo_valid = 1'b1;
            result.echo_char  = rx_char;
            result.value      = div_radix;
        end
    end

endmodule

@@ hdl/ascii_number_entry_parser_top.sv @@
// Top level of the ASCII number entry parser.
//
// Usage: received terminal bytes enter on the s_axis channel, one byte per
// item in s_axis_tdata. Each byte yields exactly one result item on m_axis:
// tdata carries echo_valid, echo_char and the current 16-bit value, and
// tlast is set when a carriage return ended the entry (value is then final).
// Digits in the selected radix accumulate, backspace removes one digit,
// other bytes pass through with echo_valid low.
// The radix (0 decimal, 1 hex) is written through cfg_we/cfg_wdata; the user
// must write it only while the block is idle, the block does not enforce it.
// The accepted byte goes through the input register, then the result
// register, where the result goes valid. Throughput: one item per cycle
// while m_axis_tready stays high; the accumulate and reciprocal divide
// sit in one combinational stage between the registers.
// Reset clears the accumulator, digit count, radix and both valid flags.
// When m_axis_tready is low the result register holds and the input
// register still takes one more item before s_axis_tready drops.
module ascii_number_entry_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    // config
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_char
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] echo_valid, [8:1] echo_char, [24:9] value
    output logic [anp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tlast    // done_res
);
    import anp_pkg::*;

    logic               radix_reg;
    logic               in_valid_reg;
    logic [CHAR_W-1:0]  in_char_reg;
    logic [VALUE_W-1:0] accum_reg;
    logic [VALUE_W-1:0] accum_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               out_valid_reg;
    anp_result_t        out_reg;
    anp_result_t        result;
    logic               advance;

    // Item moves from input register to result register
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Radix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_DEC;
        else if (cfg_we)
            radix_reg <= cfg_wdata;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_char_reg <= s_axis_tdata;
    end

    anp_step u_step (
        .radix_mode (radix_reg),
        .rx_char    (in_char_reg),
        .accum      (accum_reg),
        .count      (count_reg),
        .accum_next (accum_next),
        .count_next (count_next),
        .result     (result)
    );

    // Entry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            accum_reg <= accum_next;
            count_reg <= count_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_reg.done_res;
    assign m_axis_tdata  = {7'b0, out_reg.value, out_reg.echo_char, out_reg.echo_valid};

endmodule

@@ hdl/anp_checker.sv @@
// Port-level assertions for the ASCII number entry parser, bound to the top.
module anp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import anp_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // No echo means echo byte is zero
    a_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
        else $error("echo byte set without echo");

    // Carriage return ends entry and is never echoed
    a_cr_no_echo: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[0])
        else $error("done item was echoed");

    // Echoed bytes are never a carriage return and never end the entry
    a_echo_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |->
            m_axis_tdata[8:1] != CHAR_CR && !m_axis_tlast)
        else $error("echoed a carriage return");

endmodule

bind ascii_number_entry_parser_top anp_checker u_anp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
